// ===== rtl/hrs_pkg.sv =====
// Shared types and constants for the HTTP request header scanner.
`timescale 1ns / 1ps
package hrs_pkg;

    localparam int unsigned MaxRequestBytes = 65536;
    localparam int unsigned PosW = $clog2(MaxRequestBytes + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_MTH = 2'd1;
    localparam logic [1:0] ST_BAD_VER = 2'd2;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_TEXT = 2'd1;
    localparam logic [1:0] FMT_APP  = 2'd2;

    // Byte queued between the front (position keeping) and the back (parser).
    typedef struct packed {
        logic [7:0]  data;
        logic        in_range;
        logic [15:0] pos;
        logic        last;
    } hrs_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_post;
        logic [15:0] tgt_off;
        logic [15:0] tgt_len;
        logic [15:0] hdr_off;
        logic [1:0]  fmt;
        logic [15:0] ct_off;
        logic [15:0] ct_len;
        logic [31:0] clen;
        logic [15:0] pay_off;
        logic        pay_found;
    } hrs_result_t;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        fold_case = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

endpackage

// ===== rtl/hrs_front.sv =====
// Front end: takes bytes, stamps each with its position and range flag.
`timescale 1ns / 1ps
module hrs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  logic               end_of_buffer,
    input  logic               valid,
    output logic               ready,
    output hrs_pkg::hrs_item_t item,
    output logic               item_valid,
    input  logic               item_ready
);
    import hrs_pkg::*;

    logic [PosW-1:0] pos_reg, pos_next;
    logic            take;

    assign ready      = item_ready;
    assign item_valid = valid;
    assign take       = valid && item_ready;

    assign item.data     = data_byte;
    assign item.in_range = (pos_reg < PosW'(MaxRequestBytes));
    assign item.pos      = pos_reg[15:0];
    assign item.last     = end_of_buffer;

    always_comb
    begin
        pos_next = pos_reg;
        if (take)
        begin
            if (end_of_buffer)
                pos_next = '0;
            else if (item.in_range)
                pos_next = pos_reg + PosW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end
endmodule

// ===== rtl/hrs_queue.sv =====
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module hrs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  hrs_pkg::hrs_item_t in_item,
    input  logic               in_valid,
    output logic               in_ready,
    output hrs_pkg::hrs_item_t out_item,
    output logic               out_valid,
    input  logic               out_ready
);
    import hrs_pkg::*;

    hrs_item_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/hrs_back.sv =====
// Back end: request line and header parser, one byte per cycle unless its result register is held.
`timescale 1ns / 1ps
module hrs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hrs_pkg::hrs_item_t   item,
    input  logic                 item_valid,
    output logic                 item_ready,
    output hrs_pkg::hrs_result_t res,
    output logic                 res_valid,
    input  logic                 res_ready
);
    import hrs_pkg::*;

    typedef enum logic [2:0] {
        PH_METHOD, PH_TARGET, PH_VERSION, PH_VER_CR, PH_HEADER, PH_PAY_CR, PH_DONE
    } phase_t;

    localparam logic [15:0] M_POST = 16'h0001;
    localparam logic [15:0] M_GET  = 16'h0002;
    localparam logic [15:0] M_VER  = 16'h0004;
    localparam logic [15:0] M_ASEP = 16'h0001;
    localparam logic [15:0] M_CONT = 16'h0002;
    localparam logic [15:0] M_CTYP = 16'h0004;
    localparam logic [15:0] M_CLEN = 16'h0008;
    localparam logic [15:0] I_APP  = 16'h0010;
    localparam logic [15:0] I_APPX = 16'h0020;
    localparam logic [15:0] I_APPS = 16'h0040;
    localparam logic [15:0] I_TXT  = 16'h0080;
    localparam logic [15:0] I_TXTX = 16'h0100;
    localparam logic [15:0] I_TXTS = 16'h0200;
    localparam logic [15:0] I_STR  = 16'h0400;
    localparam logic [15:0] I_STRX = 16'h0800;
    localparam logic [15:0] I_STRS = 16'h1000;
    localparam logic [15:0] I_MASK = 16'h1FF0;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [31:0] S_POST = "POST";
    localparam logic [23:0] S_GET  = "GET";
    localparam logic [63:0] S_VER  = "HTTP/1.1";
    localparam logic [55:0] S_CONT = "content";
    localparam logic [55:0] S_TYPE = "-type: ";
    localparam logic [71:0] S_LEN  = "-length: ";
    localparam logic [87:0] S_APP  = "application";
    localparam logic [31:0] S_TEXT = "text";
    localparam logic [23:0] S_XML  = "xml";

    phase_t      ph_reg, ph_n;
    logic [15:0] tp_reg, tp_n, ts_reg, ts_n, mf_reg, mf_n, ip_reg, ip_n;
    logic        pcr_reg, pcr_n, post_reg, post_n, dec_reg, dec_n;
    logic [1:0]  fmt_reg, fmt_n, st_reg, st_n;
    logic [15:0] toff_reg, toff_n, tlen_reg, tlen_n, hoff_reg, hoff_n;
    logic [15:0] coff_reg, coff_n, clen16_reg, clen16_n, poff_reg, poff_n;
    logic [31:0] acc_reg, acc_n;
    logic        acc_on_reg, acc_on_n, ct_on_reg, ct_on_n, dg_on_reg, dg_on_n;
    logic        pay_reg, pay_n;
    hrs_result_t res_reg, res_n;
    logic        rv_reg, rv_n;
    logic        take;

    assign item_ready = !rv_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign res        = res_reg;
    assign res_valid  = rv_reg;

    function automatic logic [7:0] sch(input logic [87:0] s, input int n, input int k);
        sch = s[8*(n-1-k) +: 8];
    endfunction

    always_comb
    begin : parse
        logic [7:0]  b, c;
        logic [15:0] pos, k, n, f;
        logic [35:0] prod;
        logic        hb, mok, vok, done_hdr;

        ph_n = ph_reg; tp_n = tp_reg; ts_n = ts_reg; mf_n = mf_reg; ip_n = ip_reg;
        pcr_n = pcr_reg; post_n = post_reg; dec_n = dec_reg; fmt_n = fmt_reg;
        st_n = st_reg; toff_n = toff_reg; tlen_n = tlen_reg; hoff_n = hoff_reg;
        coff_n = coff_reg; clen16_n = clen16_reg; poff_n = poff_reg; acc_n = acc_reg;
        acc_on_n = acc_on_reg; ct_on_n = ct_on_reg; dg_on_n = dg_on_reg; pay_n = pay_reg;
        res_n = res_reg;
        rv_n = rv_reg && !res_ready;
        b = item.data; c = fold_case(b); pos = item.pos;
        k = '0; n = '0; f = '0; prod = '0;
        hb = 1'b0; mok = 1'b0; vok = 1'b0; done_hdr = 1'b0;

        if (take && item.in_range)
        begin
            // per-phase handling: request line, version CR, header entry and payload CR
            case (ph_reg)
                PH_METHOD, PH_TARGET, PH_VERSION:
                begin
                    k = tp_reg;
                    if (pcr_reg && b == CH_LF && k == 16'd0)
                    begin
                        pcr_n = 1'b0; ts_n = pos + 16'd1;
                    end
                    else
                    begin
                        pcr_n = 1'b0;
                        if (b != CH_SP && b != CH_CR && b != CH_LF)
                        begin
                            if (k < 16'd4 && b != sch(88'(S_POST), 4, 32'(k))) mf_n[0] = 1'b0;
                            if (k < 16'd3 && b != sch(88'(S_GET), 3, 32'(k)))  mf_n[1] = 1'b0;
                            if (k < 16'd8 && b != sch(88'(S_VER), 8, 32'(k)))  mf_n[2] = 1'b0;
                            tp_n = sat_inc16(k);
                        end
                        else if (ph_reg == PH_METHOD)
                        begin
                            if (k == 16'd4 && (mf_reg & M_POST) != 0)
                            begin
                                post_n = 1'b1; mok = 1'b1;
                            end
                            else if (k == 16'd3 && (mf_reg & M_GET) != 0)
                            begin
                                post_n = 1'b0; mok = 1'b1;
                            end
                            if (!mok)
                            begin
                                st_n = ST_BAD_MTH; ph_n = PH_DONE;
                            end
                            else
                            begin
                                ph_n = PH_TARGET; pcr_n = (b == CH_CR);
                                ts_n = pos + 16'd1; tp_n = '0; mf_n = '1;
                            end
                        end
                        else if (ph_reg == PH_TARGET)
                        begin
                            toff_n = ts_reg; tlen_n = k; ph_n = PH_VERSION;
                            pcr_n = (b == CH_CR); ts_n = pos + 16'd1; tp_n = '0; mf_n = '1;
                        end
                        else
                        begin
                            if (!(k == 16'd8 && (mf_reg & M_VER) != 0))
                            begin
                                st_n = ST_BAD_VER; ph_n = PH_DONE;
                            end
                            else if (b == CH_CR)
                            begin
                                hoff_n = pos + 16'd1; ph_n = PH_VER_CR;
                            end
                            else
                            begin
                                // LF ends the line; a space starts the first header line
                                hoff_n = (b == CH_LF) ? pos + 16'd1 : pos;
                                ph_n = PH_HEADER; pcr_n = 1'b0;
                                tp_n = '0; ip_n = '0; mf_n = '1;
                                acc_on_n = 1'b0; ct_on_n = 1'b0; dg_on_n = 1'b0;
                                hb = (b != CH_LF);
                            end
                        end
                    end
                end
                PH_VER_CR:
                begin
                    ph_n = PH_HEADER; pcr_n = 1'b0; tp_n = '0; ip_n = '0; mf_n = '1;
                    acc_on_n = 1'b0; ct_on_n = 1'b0; dg_on_n = 1'b0;
                    if (b == CH_LF)
                        hoff_n = pos + 16'd1;
                    else
                        hb = 1'b1;
                end
                PH_HEADER:
                    hb = 1'b1;
                PH_PAY_CR:
                begin
                    if (b == CH_LF)
                        poff_n = pos + 16'd1;
                    ph_n = PH_DONE;
                end
                default:
                    ;
            endcase

            // header byte, works on the _n copies
            if (hb)
            begin
                k = tp_n;
                if (pcr_n && b == CH_LF)
                    pcr_n = 1'b0;
                else
                begin
                    pcr_n = 1'b0;
                    if (b == CH_CR || b == CH_LF)
                    begin
                        if (k == 16'd0 && post_n)
                        begin
                            pay_n = 1'b1; poff_n = pos + 16'd1;
                            ph_n = (b == CH_CR) ? PH_PAY_CR : PH_DONE;
                        end
                        else
                        begin
                            done_hdr = 1'b1;
                            pcr_n = (b == CH_CR);
                        end
                    end
                    else
                    begin
                        if ((k == 16'd6 && b != ":") || (k == 16'd7 && b != CH_SP))
                            mf_n = mf_n & ~M_ASEP;
                        if (k <= 16'd6 && c != sch(88'(S_CONT), 7, 32'(k)))
                            mf_n = mf_n & ~M_CONT;
                        if (k >= 16'd7 && k <= 16'd13 && c != sch(88'(S_TYPE), 7, 32'(k) - 7))
                            mf_n = mf_n & ~M_CTYP;
                        if (k >= 16'd7 && k <= 16'd15 && c != sch(88'(S_LEN), 9, 32'(k) - 7))
                            mf_n = mf_n & ~M_CLEN;
                        if (k == 16'd8 && (mf_n & M_ASEP) != 0)
                        begin
                            fmt_n = FMT_NONE; dec_n = 1'b0; acc_on_n = 1'b1;
                            mf_n = mf_n | I_MASK; ip_n = '0;
                        end
                        if (post_n && (mf_n & M_CONT) != 0)
                        begin
                            if (k == 16'd14 && (mf_n & M_CTYP) != 0)
                            begin
                                ct_on_n = 1'b1; coff_n = pos; clen16_n = '0;
                            end
                            if (k == 16'd16 && (mf_n & M_CLEN) != 0)
                            begin
                                dg_on_n = 1'b1; acc_n = '0;
                            end
                        end
                        if (acc_on_n)
                        begin
                            if (b == "," || b == CH_SP)
                                done_hdr = 1'b0;
                            else
                            begin
                                n = ip_n;
                                if (n <= 16'd10 && b != sch(S_APP, 11, 32'(n))) mf_n &= ~I_APP;
                                if (n >= 16'd12 && n <= 16'd14 && b != sch(88'(S_XML), 3, 32'(n) - 12))
                                    mf_n &= ~I_APPX;
                                if (n == 16'd12 && b != "*") mf_n &= ~I_APPS;
                                if (n <= 16'd3 && b != sch(88'(S_TEXT), 4, 32'(n))) mf_n &= ~I_TXT;
                                if (n >= 16'd5 && n <= 16'd7 && b != sch(88'(S_XML), 3, 32'(n) - 5))
                                    mf_n &= ~I_TXTX;
                                if (n == 16'd5 && b != "*") mf_n &= ~I_TXTS;
                                if (n == 16'd0 && b != "*") mf_n &= ~I_STR;
                                if (n >= 16'd2 && n <= 16'd4 && b != sch(88'(S_XML), 3, 32'(n) - 2))
                                    mf_n &= ~I_STRX;
                                if (n == 16'd2 && b != "*") mf_n &= ~I_STRS;
                                ip_n = sat_inc16(n);
                            end
                        end
                        if (ct_on_n)
                            clen16_n = sat_inc16(clen16_n);
                        if (dg_on_n)
                        begin
                            if (b >= "0" && b <= "9")
                            begin
                                prod = {4'b0000, acc_n} * 36'd10 + {28'd0, b - "0"};
                                acc_n = (prod > 36'hFFFFFFFF) ? 32'hFFFFFFFF : prod[31:0];
                            end
                            else
                                dg_on_n = 1'b0;
                        end
                        tp_n = sat_inc16(k);
                    end
                end
            end
        end

        // finish at end of buffer: header phase closes its line
        if (take && item.last && (ph_n == PH_HEADER))
            done_hdr = 1'b1;

        // item end for an Accept separator or line end
        if (take && acc_on_n && hb && !done_hdr && (b == "," || b == CH_SP)
            && b != CH_CR && b != CH_LF)
            vok = 1'b1;
        if (done_hdr && acc_on_n)
            vok = 1'b1;
        if (vok)
        begin
            n = ip_n; f = mf_n;
            if (!dec_n)
            begin
                if ((f & I_APP) != 0 && n > 16'd11 &&
                    ((n >= 16'd15 && (f & I_APPX) != 0) || (n >= 16'd13 && (f & I_APPS) != 0)))
                begin
                    fmt_n = FMT_APP; dec_n = 1'b1;
                end
                else if ((f & I_TXT) != 0 && n > 16'd4 &&
                    ((n >= 16'd8 && (f & I_TXTX) != 0) || (n >= 16'd6 && (f & I_TXTS) != 0)))
                begin
                    fmt_n = FMT_TEXT; dec_n = 1'b1;
                end
                else if ((f & I_STR) != 0 && n > 16'd1 &&
                    ((n >= 16'd5 && (f & I_STRX) != 0) || (n >= 16'd3 && (f & I_STRS) != 0)))
                begin
                    fmt_n = FMT_TEXT; dec_n = 1'b1;
                end
            end
            mf_n = mf_n | I_MASK; ip_n = '0;
        end
        if (done_hdr)
        begin
            acc_on_n = 1'b0; ct_on_n = 1'b0; dg_on_n = 1'b0;
            tp_n = '0; ip_n = '0; mf_n = '1;
        end

        if (take && item.last)
        begin
            case (ph_n)
                PH_METHOD:
                    st_n = (tp_n == 16'd4 && (mf_n & M_POST) != 0) ? ST_BAD_VER :
                           (tp_n == 16'd3 && (mf_n & M_GET) != 0)  ? ST_BAD_VER : ST_BAD_MTH;
                PH_TARGET:
                    st_n = ST_BAD_VER;
                PH_VERSION:
                    if (tp_n == 16'd8 && (mf_n & M_VER) != 0)
                        hoff_n = ts_n + 16'd8;
                    else
                        st_n = ST_BAD_VER;
                default:
                    ;
            endcase
            if (ph_n == PH_METHOD && tp_n == 16'd4 && (mf_n & M_POST) != 0)
                post_n = 1'b1;
            res_n = '0;
            res_n.status = st_n;
            if (st_n != ST_BAD_MTH)
                res_n.is_post = post_n;
            if (st_n == ST_OK)
            begin
                res_n.tgt_off = toff_n; res_n.tgt_len = tlen_n; res_n.hdr_off = hoff_n;
                res_n.fmt = fmt_n; res_n.ct_off = coff_n; res_n.ct_len = clen16_n;
                res_n.clen = acc_n; res_n.pay_off = poff_n; res_n.pay_found = pay_n;
            end
            rv_n = 1'b1;
            ph_n = PH_METHOD; tp_n = '0; ts_n = '0; mf_n = '1; ip_n = '0;
            pcr_n = 1'b0; post_n = 1'b0; dec_n = 1'b0; fmt_n = FMT_TEXT; st_n = ST_OK;
            toff_n = '0; tlen_n = '0; hoff_n = '0; coff_n = '0; clen16_n = '0;
            poff_n = '0; acc_n = '0; acc_on_n = 1'b0; ct_on_n = 1'b0; dg_on_n = 1'b0;
            pay_n = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_METHOD; tp_reg <= '0; ts_reg <= '0; mf_reg <= '1; ip_reg <= '0;
            pcr_reg <= 1'b0; post_reg <= 1'b0; dec_reg <= 1'b0; fmt_reg <= FMT_TEXT;
            st_reg <= ST_OK; toff_reg <= '0; tlen_reg <= '0; hoff_reg <= '0;
            coff_reg <= '0; clen16_reg <= '0; poff_reg <= '0; acc_reg <= '0;
            acc_on_reg <= 1'b0; ct_on_reg <= 1'b0; dg_on_reg <= 1'b0; pay_reg <= 1'b0;
            res_reg <= '0; rv_reg <= 1'b0;
        end
        else
        begin
            ph_reg <= ph_n; tp_reg <= tp_n; ts_reg <= ts_n; mf_reg <= mf_n; ip_reg <= ip_n;
            pcr_reg <= pcr_n; post_reg <= post_n; dec_reg <= dec_n; fmt_reg <= fmt_n;
            st_reg <= st_n; toff_reg <= toff_n; tlen_reg <= tlen_n; hoff_reg <= hoff_n;
            coff_reg <= coff_n; clen16_reg <= clen16_n; poff_reg <= poff_n; acc_reg <= acc_n;
            acc_on_reg <= acc_on_n; ct_on_reg <= ct_on_n; dg_on_reg <= dg_on_n;
            pay_reg <= pay_n; res_reg <= res_n; rv_reg <= rv_n;
        end
    end
endmodule

// ===== rtl/http_request_header_scanner.sv =====
// Top level of the HTTP request header scanner.
`timescale 1ns / 1ps
//
//  channel | signals                         | transfer when
//  --------+---------------------------------+-------------------------
//  input   | data_byte, end_of_buffer        | in_valid && in_ready
//  result  | parse_status .. payload_found   | out_valid && out_ready
//
// One byte per cycle while results are taken; the back end parser takes
// one byte per cycle unless its result register is held, and the result
// appears, registered, in the cycle after the final byte leaves the
// two-entry queue. Reset (rst_n low, asynchronous) returns every phase to
// the request method; a held result fills the queue, then stalls the front.
module http_request_header_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  parse_status,
    output logic        method_is_post,
    output logic [15:0] target_offset,
    output logic [15:0] target_length,
    output logic [15:0] header_offset,
    output logic [1:0]  response_format,
    output logic [15:0] content_type_offset,
    output logic [15:0] content_type_length,
    output logic [31:0] content_length,
    output logic [15:0] payload_offset,
    output logic        payload_found
);
    import hrs_pkg::*;

    hrs_item_t   f_item, q_item;
    logic        f_valid, f_ready, q_valid, q_ready;
    hrs_result_t res;

    hrs_front u_front (
        .clk, .rst_n, .data_byte, .end_of_buffer,
        .valid(in_valid), .ready(in_ready),
        .item(f_item), .item_valid(f_valid), .item_ready(f_ready)
    );

    hrs_queue u_queue (
        .clk, .rst_n,
        .in_item(f_item), .in_valid(f_valid), .in_ready(f_ready),
        .out_item(q_item), .out_valid(q_valid), .out_ready(q_ready)
    );

    hrs_back u_back (
        .clk, .rst_n,
        .item(q_item), .item_valid(q_valid), .item_ready(q_ready),
        .res(res), .res_valid(out_valid), .res_ready(out_ready)
    );

    assign parse_status        = res.status;
    assign method_is_post      = res.is_post;
    assign target_offset       = res.tgt_off;
    assign target_length       = res.tgt_len;
    assign header_offset       = res.hdr_off;
    assign response_format     = res.fmt;
    assign content_type_offset = res.ct_off;
    assign content_type_length = res.ct_len;
    assign content_length      = res.clen;
    assign payload_offset      = res.pay_off;
    assign payload_found       = res.pay_found;
endmodule

// ===== tb/sv/http_request_header_scanner_test.sv =====
// Testbench for the HTTP request header scanner: request streams against a local parser model.
`timescale 1ns / 1ps
module http_request_header_scanner_test;
    import hrs_pkg::*;

    // ------------------------------------------------------------------
    // Parser phases and match bits of the local model
    // ------------------------------------------------------------------
    localparam int unsigned PH_METHOD  = 0;
    localparam int unsigned PH_TARGET  = 1;
    localparam int unsigned PH_VERSION = 2;
    localparam int unsigned PH_VER_CR  = 3;
    localparam int unsigned PH_HEADER  = 4;
    localparam int unsigned PH_PAY_CR  = 5;
    localparam int unsigned PH_DONE    = 6;

    localparam logic [15:0] M_POST   = 16'h0001;
    localparam logic [15:0] M_GET    = 16'h0002;
    localparam logic [15:0] M_VER    = 16'h0004;
    localparam logic [15:0] M_ASEP   = 16'h0001;
    localparam logic [15:0] M_CONT   = 16'h0002;
    localparam logic [15:0] M_CTYP   = 16'h0004;
    localparam logic [15:0] M_CLEN   = 16'h0008;
    localparam logic [15:0] I_APP    = 16'h0010;
    localparam logic [15:0] I_APPX   = 16'h0020;
    localparam logic [15:0] I_APPS   = 16'h0040;
    localparam logic [15:0] I_TXT    = 16'h0080;
    localparam logic [15:0] I_TXTX   = 16'h0100;
    localparam logic [15:0] I_TXTS   = 16'h0200;
    localparam logic [15:0] I_STR    = 16'h0400;
    localparam logic [15:0] I_STRX   = 16'h0800;
    localparam logic [15:0] I_STRS   = 16'h1000;
    localparam logic [15:0] I_MASK   = 16'h1FF0;
    localparam logic [15:0] ALL_LIVE = 16'hFFFF;

    localparam int unsigned CAP_TARGET  = 0;
    localparam int unsigned CAP_HEADER  = 1;
    localparam int unsigned CAP_CTYPE   = 2;
    localparam int unsigned CAP_PAYLOAD = 3;

    localparam int unsigned CHR_CR = 13;
    localparam int unsigned CHR_LF = 10;

    localparam int STALL_LIMIT = 500;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        end_of_buffer = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  parse_status;
    logic        method_is_post;
    logic [15:0] target_offset;
    logic [15:0] target_length;
    logic [15:0] header_offset;
    logic [1:0]  response_format;
    logic [15:0] content_type_offset;
    logic [15:0] content_type_length;
    logic [31:0] content_length;
    logic [15:0] payload_offset;
    logic        payload_found;

    always #5 clk = ~clk;

    http_request_header_scanner dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .end_of_buffer(end_of_buffer),
        .out_valid(out_valid), .out_ready(out_ready),
        .parse_status(parse_status), .method_is_post(method_is_post),
        .target_offset(target_offset), .target_length(target_length),
        .header_offset(header_offset), .response_format(response_format),
        .content_type_offset(content_type_offset),
        .content_type_length(content_type_length),
        .content_length(content_length), .payload_offset(payload_offset),
        .payload_found(payload_found)
    );

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    hrs_result_t expected_summaries[$];
    byte unsigned req[$];
    int errors = 0;
    int bytes_sent = 0;
    int requests_sent = 0;
    int summaries_checked = 0;
    bit send_burst = 0;    // no sender gaps for this request
    bit recv_burst = 0;    // no receiver stalls for a while

    // ------------------------------------------------------------------
    // Local scanner model
    // ------------------------------------------------------------------
    int unsigned scan_phase, scan_bytepos, scan_tokpos, scan_tokstart, scan_itempos;
    logic [15:0] scan_flags;
    bit          scan_prev_cr, scan_post, scan_fmt_decided;
    bit          scan_accept_on, scan_ctype_on, scan_digits_on, scan_payload_seen;
    int unsigned scan_fmt, scan_status;
    int unsigned cap_off [4];
    int unsigned cap_len [4];
    logic [31:0] scan_clen;

    function automatic int unsigned sat16(int unsigned v);
        return (v < 65535) ? v + 1 : v;
    endfunction

    function automatic int unsigned lower(int unsigned b);
        return (b >= 65 && b <= 90) ? b + 32 : b;
    endfunction

    function automatic int unsigned chr(string s, int unsigned k);
        return (k < s.len()) ? s[k] : 0;
    endfunction

    function automatic void kill(logic [15:0] m, bit mis);
        if (mis) scan_flags &= ~m;
    endfunction

    function automatic void scan_reset();
        scan_phase = PH_METHOD;
        scan_bytepos = 0; scan_tokpos = 0; scan_tokstart = 0; scan_itempos = 0;
        scan_flags = ALL_LIVE;
        scan_prev_cr = 0; scan_post = 0;
        scan_fmt = 1; scan_fmt_decided = 0;
        for (int j = 0; j < 4; j++)
        begin
            cap_off[j] = 0;
            cap_len[j] = 0;
        end
        scan_clen = 0; scan_status = 0;
        scan_accept_on = 0; scan_ctype_on = 0; scan_digits_on = 0; scan_payload_seen = 0;
    endfunction

    function automatic void accept_item_byte(int unsigned b);
        int unsigned k;
        k = scan_itempos;
        kill(I_APP, k <= 10 && b != chr("application", k));
        kill(I_APPX, k >= 12 && k <= 14 && b != chr("xml", k - 12));
        kill(I_APPS, k == 12 && b != 42);
        kill(I_TXT, k <= 3 && b != chr("text", k));
        kill(I_TXTX, k >= 5 && k <= 7 && b != chr("xml", k - 5));
        kill(I_TXTS, k == 5 && b != 42);
        kill(I_STR, k == 0 && b != 42);
        kill(I_STRX, k >= 2 && k <= 4 && b != chr("xml", k - 2));
        kill(I_STRS, k == 2 && b != 42);
        scan_itempos = sat16(k);
    endfunction

    // first matching item decides the format
    function automatic void accept_item_end();
        int unsigned n;
        logic [15:0] f;
        n = scan_itempos;
        f = scan_flags;
        if (!scan_fmt_decided)
        begin
            if ((f & I_APP) != 0 && n > 11 &&
                ((n >= 15 && (f & I_APPX) != 0) || (n >= 13 && (f & I_APPS) != 0)))
            begin
                scan_fmt = 2; scan_fmt_decided = 1;
            end
            else if ((f & I_TXT) != 0 && n > 4 &&
                ((n >= 8 && (f & I_TXTX) != 0) || (n >= 6 && (f & I_TXTS) != 0)))
            begin
                scan_fmt = 1; scan_fmt_decided = 1;
            end
            else if ((f & I_STR) != 0 && n > 1 &&
                ((n >= 5 && (f & I_STRX) != 0) || (n >= 3 && (f & I_STRS) != 0)))
            begin
                scan_fmt = 1; scan_fmt_decided = 1;
            end
        end
        scan_flags |= I_MASK;
        scan_itempos = 0;
    endfunction

    function automatic void line_start();
        scan_accept_on = 0; scan_ctype_on = 0; scan_digits_on = 0;
        scan_tokpos = 0; scan_itempos = 0; scan_flags = ALL_LIVE;
    endfunction

    function automatic void line_close();
        if (scan_accept_on) accept_item_end();
        line_start();
    endfunction

    function automatic void header_byte(int unsigned b, int unsigned pos);
        int unsigned i, c;
        i = scan_tokpos;
        c = lower(b);
        if (scan_prev_cr && b == CHR_LF)
        begin
            scan_prev_cr = 0;
            return;
        end
        scan_prev_cr = 0;
        if (b == CHR_CR || b == CHR_LF)
        begin
            if (i == 0 && scan_post)
            begin
                scan_payload_seen = 1;
                cap_off[CAP_PAYLOAD] = pos + 1;
                scan_phase = (b == CHR_CR) ? PH_PAY_CR : PH_DONE;
                return;
            end
            line_close();
            scan_prev_cr = (b == CHR_CR);
            return;
        end
        kill(M_ASEP, (i == 6 && b != 58) || (i == 7 && b != 32));
        kill(M_CONT, i <= 6 && c != chr("content", i));
        kill(M_CTYP, i >= 7 && i <= 13 && c != chr("-type: ", i - 7));
        kill(M_CLEN, i >= 7 && i <= 15 && c != chr("-length: ", i - 7));
        if (i == 8 && (scan_flags & M_ASEP) != 0)
        begin
            scan_fmt = 0; scan_fmt_decided = 0; scan_accept_on = 1;
            scan_flags |= I_MASK; scan_itempos = 0;
        end
        if (scan_post && (scan_flags & M_CONT) != 0)
        begin
            if (i == 14 && (scan_flags & M_CTYP) != 0)
            begin
                scan_ctype_on = 1;
                cap_off[CAP_CTYPE] = pos;
                cap_len[CAP_CTYPE] = 0;
            end
            if (i == 16 && (scan_flags & M_CLEN) != 0)
            begin
                scan_digits_on = 1;
                scan_clen = 0;
            end
        end
        if (scan_accept_on)
        begin
            if (b == 44 || b == 32) accept_item_end();
            else accept_item_byte(b);
        end
        if (scan_ctype_on) cap_len[CAP_CTYPE] = sat16(cap_len[CAP_CTYPE]);
        if (scan_digits_on)
        begin
            if (b >= 48 && b <= 57)
            begin
                longint unsigned v;
                v = longint'(scan_clen) * 10 + (b - 48);
                scan_clen = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            end
            else
                scan_digits_on = 0;
        end
        scan_tokpos = sat16(i);
    endfunction

    function automatic bit method_good();
        if (scan_tokpos == 4 && (scan_flags & M_POST) != 0)
        begin
            scan_post = 1;
            return 1;
        end
        if (scan_tokpos == 3 && (scan_flags & M_GET) != 0)
        begin
            scan_post = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit version_good();
        return scan_tokpos == 8 && (scan_flags & M_VER) != 0;
    endfunction

    function automatic void enter_headers();
        scan_phase = PH_HEADER;
        scan_prev_cr = 0;
        line_start();
    endfunction

    function automatic void request_line_byte(int unsigned b, int unsigned pos);
        int unsigned k;
        k = scan_tokpos;
        if (scan_prev_cr && b == CHR_LF && k == 0)
        begin
            scan_prev_cr = 0;
            scan_tokstart = pos + 1;
            return;
        end
        scan_prev_cr = 0;
        if (b != 32 && b != CHR_CR && b != CHR_LF)
        begin
            kill(M_POST, k < 4 && b != chr("POST", k));
            kill(M_GET, k < 3 && b != chr("GET", k));
            kill(M_VER, k < 8 && b != chr("HTTP/1.1", k));
            scan_tokpos = sat16(k);
            return;
        end
        if (scan_phase == PH_METHOD)
        begin
            if (!method_good())
            begin
                scan_status = ST_BAD_MTH;
                scan_phase = PH_DONE;
                return;
            end
            scan_phase = PH_TARGET;
        end
        else if (scan_phase == PH_TARGET)
        begin
            cap_off[CAP_TARGET] = scan_tokstart;
            cap_len[CAP_TARGET] = k;
            scan_phase = PH_VERSION;
        end
        else
        begin
            if (!version_good())
            begin
                scan_status = ST_BAD_VER;
                scan_phase = PH_DONE;
                return;
            end
            if (b == CHR_CR)
            begin
                cap_off[CAP_HEADER] = pos + 1;
                scan_phase = PH_VER_CR;
                return;
            end
            if (b == CHR_LF)
            begin
                cap_off[CAP_HEADER] = pos + 1;
                enter_headers();
                return;
            end
            // space after the version starts the first header line
            cap_off[CAP_HEADER] = pos;
            enter_headers();
            header_byte(b, pos);
            return;
        end
        scan_prev_cr = (b == CHR_CR);
        scan_tokstart = pos + 1;
        scan_tokpos = 0;
        scan_flags = ALL_LIVE;
    endfunction

    // Advances the model by one byte; returns 1 with the summary on the final byte.
    function automatic bit scan_byte(int unsigned b, bit last, output hrs_result_t r);
        r = '0;
        if (scan_bytepos < MaxRequestBytes)
        begin
            int unsigned pos;
            pos = scan_bytepos;
            scan_bytepos++;
            case (scan_phase)
                PH_METHOD, PH_TARGET, PH_VERSION: request_line_byte(b, pos);
                PH_VER_CR:
                begin
                    if (b == CHR_LF)
                    begin
                        cap_off[CAP_HEADER] = pos + 1;
                        enter_headers();
                    end
                    else
                    begin
                        enter_headers();
                        header_byte(b, pos);
                    end
                end
                PH_HEADER: header_byte(b, pos);
                PH_PAY_CR:
                begin
                    if (b == CHR_LF) cap_off[CAP_PAYLOAD] = pos + 1;
                    scan_phase = PH_DONE;
                end
                default: ;
            endcase
        end
        if (!last) return 0;
        case (scan_phase)
            PH_METHOD:  scan_status = method_good() ? ST_BAD_VER : ST_BAD_MTH;
            PH_TARGET:  scan_status = ST_BAD_VER;
            PH_VERSION:
            begin
                if (version_good()) cap_off[CAP_HEADER] = scan_tokstart + 8;
                else scan_status = ST_BAD_VER;
            end
            PH_HEADER:  line_close();
            default: ;
        endcase
        r.status = scan_status[1:0];
        if (scan_status != ST_BAD_MTH) r.is_post = scan_post;
        if (scan_status == ST_OK)
        begin
            r.tgt_off   = cap_off[CAP_TARGET][15:0];
            r.tgt_len   = cap_len[CAP_TARGET][15:0];
            r.hdr_off   = cap_off[CAP_HEADER][15:0];
            r.fmt       = scan_fmt[1:0];
            r.ct_off    = cap_off[CAP_CTYPE][15:0];
            r.ct_len    = cap_len[CAP_CTYPE][15:0];
            r.clen      = scan_clen;
            r.pay_off   = cap_off[CAP_PAYLOAD][15:0];
            r.pay_found = scan_payload_seen;
        end
        scan_reset();
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_byte(byte unsigned b, bit last);
        int gap;
        bit rdy;
        hrs_result_t r;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_buffer <= last;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        // transfer taken at this edge
        bytes_sent++;
        if (scan_byte(b, last, r)) expected_summaries.push_back(r);
    endtask

    task automatic send_request();
        send_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < req.size(); i++)
            send_byte(req[i], i == req.size() - 1);
        if (req.size() > 0) requests_sent++;
        req.delete();
    endtask

    task automatic put(string s);
        for (int i = 0; i < s.len(); i++)
            req.push_back(s[i]);
    endtask

    task automatic send_text(string s);
        put(s);
        send_request();
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    task automatic report(string field, longint unsigned got, longint unsigned want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", field, got, want,
                 summaries_checked);
    endtask

    initial
    begin
        hrs_result_t g, e;
        int stall;
        bit v;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0) recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                v = out_valid;
                g = '{parse_status, method_is_post, target_offset, target_length,
                      header_offset, response_format, content_type_offset,
                      content_type_length, content_length, payload_offset, payload_found};
                @(posedge clk);
            end
            while (!v);
            if (expected_summaries.size() == 0)
            begin
                errors++;
                $display("MISMATCH unexpected result with nothing pending");
            end
            else
            begin
                e = expected_summaries.pop_front();
                if (g.status    !== e.status)    report("parse_status", g.status, e.status);
                if (g.is_post   !== e.is_post)   report("method_is_post", g.is_post, e.is_post);
                if (g.tgt_off   !== e.tgt_off)   report("target_offset", g.tgt_off, e.tgt_off);
                if (g.tgt_len   !== e.tgt_len)   report("target_length", g.tgt_len, e.tgt_len);
                if (g.hdr_off   !== e.hdr_off)   report("header_offset", g.hdr_off, e.hdr_off);
                if (g.fmt       !== e.fmt)       report("response_format", g.fmt, e.fmt);
                if (g.ct_off    !== e.ct_off)
                    report("content_type_offset", g.ct_off, e.ct_off);
                if (g.ct_len    !== e.ct_len)
                    report("content_type_length", g.ct_len, e.ct_len);
                if (g.clen      !== e.clen)      report("content_length", g.clen, e.clen);
                if (g.pay_off   !== e.pay_off)   report("payload_offset", g.pay_off, e.pay_off);
                if (g.pay_found !== e.pay_found)
                    report("payload_found", g.pay_found, e.pay_found);
                summaries_checked++;
            end
        end
    end

    // Watchdog: cycles with work pending but no transfer on either side.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (!in_valid && expected_summaries.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_request_line();
        send_text("GET /index.html HTTP/1.1\r\n\r\n");
        send_text("POST /a HTTP/1.1\nHost: x\n\nbody");
        send_text("PUT / HTTP/1.1\r\n\r\n");             // bad method
        send_text("GET / HTTP/1.0\r\n\r\n");             // bad version
        send_text("GET");                                // method only, ends in buffer
        send_text("GET /x");                             // no version
        send_text("GET /x HTTP/1.1");                    // version ends the buffer
        send_text("GET  HTTP/1.1\r\n");                  // empty target
        send_text("GET /y HTTP/1.1 Accept: */*\r\n");    // space ends the version
        send_text("POST /p HTTP/1.1\r");                 // buffer ends on CR
        req.push_back(8'h00);
        send_request();
        req.push_back(8'hFF);
        send_request();
        send_text("\r\nGET / HTTP/1.1\r\n");
    endtask

    task automatic test_accept_formats();
        send_text("GET / HTTP/1.1\r\nAccept: application/xml\r\n\r\n");
        send_text("GET / HTTP/1.1\r\nAccept: text/html, application/*\r\n");
        send_text("GET / HTTP/1.1\r\nAccept: text/xml\r\n");
        send_text("GET / HTTP/1.1\r\nAccept: image/png text/*\r\n");
        send_text("GET / HTTP/1.1\r\nAccept: */xml\r\n");
        send_text("GET / HTTP/1.1\r\nAccept: */*,application/xml\r\n");
        send_text("GET / HTTP/1.1\r\nAccept: image/png\r\n");
        send_text("GET / HTTP/1.1\r\nAccept: text/xml\r\nAccept: foo\r\n"); // later wins
    endtask

    task automatic test_post_fields();
        send_text("POST /f HTTP/1.1\r\nContent-Type: text/xml\r\nContent-Length: 42\r\n\r\nxy");
        send_text("POST /f HTTP/1.1\r\ncontent-LENGTH: 99999999999\r\n\r\n");  // saturates
        send_text("POST /f HTTP/1.1\r\nContent-Length: +5\r\nContent-Length: 7x\r\n\r");
        send_text("POST /f HTTP/1.1\r\nContent-Type: \r\n\r\n");
        send_text("POST /f HTTP/1.1\r\nContent-Length: 12\r\n");            // no empty line
    endtask

    task automatic put_random_header();
        string items [11] = '{"application/xml", "application/*", "text/xml", "text/*",
                              "*/xml", "*/*", "text/html", "image/png", "application/json",
                              "applicationxml", "*"};
        string seps [3] = '{", ", " ", ","};
        case ($urandom_range(0, 6))
            0, 1:
            begin
                put($urandom_range(0, 4) == 0 ? "Accepx: " : "Accept: ");
                repeat ($urandom_range(1, 4))
                begin
                    put(items[$urandom_range(0, 10)]);
                    put(seps[$urandom_range(0, 2)]);
                end
            end
            2:
            begin
                if ($urandom_range(0, 1))
                    put("Content-Type: application/xml");
                else
                    put("content-type: t");
            end
            3:
            begin
                put($urandom_range(0, 1) ? "Content-Length: " : "CONTENT-length: ");
                case ($urandom_range(0, 3))
                    0: put($sformatf("%0d", $urandom));
                    1: put("98765432109876");
                    2: put($urandom_range(0, 1) ? "-3" : " 8");
                    default: put($sformatf("%0d", $urandom_range(0, 999)));
                endcase
            end
            4: put("Host: h");
            default:
                repeat ($urandom_range(0, 12)) req.push_back($urandom_range(33, 126));
        endcase
        if ($urandom_range(0, 3) == 0)
            put("\n");
        else
            put("\r\n");
    endtask

    task automatic put_random_request();
        string eol;
        if ($urandom_range(0, 3) == 0)
            eol = "\n";
        else
            eol = "\r\n";
        case ($urandom_range(0, 9))
            0: put("PUT");
            1: put("get");
            2, 3, 4, 5: put("GET");
            default: put("POST");
        endcase
        put(" /");
        repeat ($urandom_range(0, 8)) req.push_back($urandom_range(33, 126));
        put($urandom_range(0, 9) == 0 ? " HTTP/1.0" : " HTTP/1.1");
        put(eol);
        repeat ($urandom_range(0, 3)) put_random_header();
        put(eol);
        repeat ($urandom_range(0, 4)) req.push_back($urandom_range(0, 255));
    endtask

    task automatic test_random_requests();
        while (bytes_sent < 1600)
        begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 20)) req.push_back($urandom_range(0, 255));
                1:
                begin
                    // corrupted and possibly truncated well-formed request
                    put_random_request();
                    req[$urandom_range(0, req.size() - 1)] = $urandom_range(0, 255);
                    while (req.size() > 1 && $urandom_range(0, 2) != 0) void'(req.pop_back());
                end
                default: put_random_request();
            endcase
            send_request();
        end
    endtask

    task automatic test_drain_pause();
        send_text("POST /d HTTP/1.1\r\nContent-Length: 5\r\n\r\nabcde");
        in_valid <= 1'b0;
        while (expected_summaries.size() != 0) @(posedge clk);
        send_text("GET /e HTTP/1.1\r\nAccept: text/*\r\n");
    endtask

    initial
    begin
        int waited;
        scan_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_line();
        test_accept_formats();
        test_post_fields();
        test_drain_pause();
        test_random_requests();
        in_valid <= 1'b0;
        waited = 0;
        while (expected_summaries.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (expected_summaries.size() != 0)
        begin
            errors++;
            $display("MISMATCH %0d results never arrived", expected_summaries.size());
        end
        $display("Sent %0d requests in %0d bytes, checked %0d result summaries", requests_sent,
                 bytes_sent, summaries_checked);
        $display("Covered methods, versions, Accept forms, POST fields, random byte streams");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== http_request_header_scanner.f =====
rtl/hrs_pkg.sv
rtl/hrs_front.sv
rtl/hrs_queue.sv
rtl/hrs_back.sv
rtl/http_request_header_scanner.sv
tb/sv/http_request_header_scanner_test.sv
